FILE: sv/html_entity_to_utf8_filter_assert.svh
// Assertion macros for the entity filter.
`ifndef HTML_ENTITY_TO_UTF8_FILTER_ASSERT_SVH
`define HTML_ENTITY_TO_UTF8_FILTER_ASSERT_SVH

// Clocked assertion with async low reset disable.
`define HEF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("entity filter assertion failed");

// Same, with a caller message.
`define HEF_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: sv/hefilt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hefilt_pkg
// Types, constants and entity table for the HTML entity to UTF-8 filter.
// ----------------------------------------------------------------------------
package hefilt_pkg;

  localparam int NameBufferDef = 32;
  localparam int NumEntries    = 52;
  localparam int KeepEntries   = 5;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [39:0] AmpLit = 40'h26616D703B;
  localparam logic [23:0] FffdSeq = 24'hEFBFBD;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
  } out_t;

  typedef struct packed {
    logic [47:0] nm;
    logic [2:0]  nlen;
    logic [23:0] seq;
    logic [1:0]  slen;
  } ent_t;

  function automatic ent_t entry(input logic [5:0] k);
    ent_t e;
    e = '{nm: 48'h0, nlen: 3'd0, seq: 24'h0, slen: 2'd0};
    case (k)
      6'd0:  e = '{"amp", 3'd3, 24'h0, 2'd0};
      6'd1:  e = '{"lt", 3'd2, 24'h0, 2'd0};
      6'd2:  e = '{"gt", 3'd2, 24'h0, 2'd0};
      6'd3:  e = '{"quot", 3'd4, 24'h0, 2'd0};
      6'd4:  e = '{"apos", 3'd4, 24'h0, 2'd0};
      6'd5:  e = '{"aelig", 3'd5, 24'h00C3A6, 2'd2};
      6'd6:  e = '{"agrave", 3'd6, 24'h00C3A0, 2'd2};
      6'd7:  e = '{"auml", 3'd4, 24'h00C3A4, 2'd2};
      6'd8:  e = '{"bull", 3'd4, 24'hE280A2, 2'd3};
      6'd9:  e = '{"ccedil", 3'd6, 24'h00C3A7, 2'd2};
      6'd10: e = '{"cent", 3'd4, 24'h00C2A2, 2'd2};
      6'd11: e = '{"copy", 3'd4, 24'h00C2A9, 2'd2};
      6'd12: e = '{"dagger", 3'd6, 24'hE280A0, 2'd3};
      6'd13: e = '{"Dagger", 3'd6, 24'hE280A1, 2'd3};
      6'd14: e = '{"deg", 3'd3, 24'h00C2B0, 2'd2};
      6'd15: e = '{"divide", 3'd6, 24'h00C3B7, 2'd2};
      6'd16: e = '{"eacute", 3'd6, 24'h00C3A9, 2'd2};
      6'd17: e = '{"egrave", 3'd6, 24'h00C3A8, 2'd2};
      6'd18: e = '{"euro", 3'd4, 24'hE282AC, 2'd3};
      6'd19: e = '{"frac12", 3'd6, 24'h00C2BD, 2'd2};
      6'd20: e = '{"frac14", 3'd6, 24'h00C2BC, 2'd2};
      6'd21: e = '{"hellip", 3'd6, 24'hE280A6, 2'd3};
      6'd22: e = '{"laquo", 3'd5, 24'h00C2AB, 2'd2};
      6'd23: e = '{"ldquo", 3'd5, 24'hE2809C, 2'd3};
      6'd24: e = '{"lsquo", 3'd5, 24'hE28098, 2'd3};
      6'd25: e = '{"mdash", 3'd5, 24'hE28094, 2'd3};
      6'd26: e = '{"middot", 3'd6, 24'h00C2B7, 2'd2};
      6'd27: e = '{"minus", 3'd5, 24'hE28892, 2'd3};
      6'd28: e = '{"nbsp", 3'd4, 24'h00C2A0, 2'd2};
      6'd29: e = '{"ndash", 3'd5, 24'hE28093, 2'd3};
      6'd30: e = '{"ntilde", 3'd6, 24'h00C3B1, 2'd2};
      6'd31: e = '{"oelig", 3'd5, 24'h00C593, 2'd2};
      6'd32: e = '{"ouml", 3'd4, 24'h00C3B6, 2'd2};
      6'd33: e = '{"para", 3'd4, 24'h00C2B6, 2'd2};
      6'd34: e = '{"permil", 3'd6, 24'hE280B0, 2'd3};
      6'd35: e = '{"plusmn", 3'd6, 24'h00C2B1, 2'd2};
      6'd36: e = '{"pound", 3'd5, 24'h00C2A3, 2'd2};
      6'd37: e = '{"prime", 3'd5, 24'hE280B2, 2'd3};
      6'd38: e = '{"Prime", 3'd5, 24'hE280B3, 2'd3};
      6'd39: e = '{"raquo", 3'd5, 24'h00C2BB, 2'd2};
      6'd40: e = '{"rdquo", 3'd5, 24'hE2809D, 2'd3};
      6'd41: e = '{"reg", 3'd3, 24'h00C2AE, 2'd2};
      6'd42: e = '{"rsquo", 3'd5, 24'hE28099, 2'd3};
      6'd43: e = '{"sect", 3'd4, 24'h00C2A7, 2'd2};
      6'd44: e = '{"shy", 3'd3, 24'h00C2AD, 2'd2};
      6'd45: e = '{"sup2", 3'd4, 24'h00C2B2, 2'd2};
      6'd46: e = '{"sup3", 3'd4, 24'h00C2B3, 2'd2};
      6'd47: e = '{"szlig", 3'd5, 24'h00C39F, 2'd2};
      6'd48: e = '{"times", 3'd5, 24'h00C397, 2'd2};
      6'd49: e = '{"trade", 3'd5, 24'hE284A2, 2'd3};
      6'd50: e = '{"uuml", 3'd4, 24'h00C3BC, 2'd2};
      6'd51: e = '{"yen", 3'd3, 24'h00C2A5, 2'd2};
      default: e = '{48'h0, 3'd0, 24'h0, 2'd0};
    endcase
    return e;
  endfunction

endpackage

FILE: sv/html_entity_to_utf8_filter.sv
`timescale 1ns / 1ps
// An accepted byte first moves the filter into its emit state; its result bytes
// then pass through the output register. No new input byte is taken until all N
// result bytes (up to 36 at defaults) leave the single byte sequencer that drives the output register.
// A name byte or an opening '&' yields no result byte and leaves the input ready.
// Reset: asynchronous, active low; clears the name state and the output valid.
// ----------------------------------------------------------------------------
// html_entity_to_utf8_filter
// Filters HTML named entities in a byte stream into UTF-8, one result byte
// per cycle while out_ready_i allows, from a prefix / name / suffix byte sequencer.
// ----------------------------------------------------------------------------
`include "html_entity_to_utf8_filter_assert.svh"

module html_entity_to_utf8_filter #(
  parameter int NAME_BUFFER = hefilt_pkg::NameBufferDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hefilt_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hefilt_pkg::out_t out_data_o
);

  localparam int MaxLen   = NAME_BUFFER - 2;
  localparam int LenW     = $clog2(MaxLen + 1);
  localparam int AddrW    = $clog2(MaxLen);
  localparam int IdxW     = $clog2(MaxLen + 7);
  localparam int NE       = hefilt_pkg::NumEntries;
  localparam int KE       = hefilt_pkg::KeepEntries;

  typedef enum logic {StIdle, StEmit} state_e;

  state_e          state_q, state_d;
  logic            inside_q, inside_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      store_q [MaxLen];
  logic            wr_en;
  logic [NE-1:0]   match_q, match_d;
  logic [39:0]     pre_q, pre_d;
  logic [2:0]      pre_len_q, pre_len_d;
  logic [LenW-1:0] emit_n_q, emit_n_d;
  logic            suf_v_q, suf_v_d;
  logic [7:0]      suf_q, suf_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] total_q, total_d;
  logic            out_valid_q, out_valid_d;
  hefilt_pkg::out_t out_q, out_d;

  logic       accept;
  logic [7:0] c;
  logic       eos;
  logic       name_byte;
  logic [NE-1:0] hit;
  logic       keep;
  logic       found;
  logic [23:0] seq_sel;
  logic [1:0]  slen_sel;
  logic [7:0]  emit_byte;
  logic [2:0]  pidx;
  logic [IdxW-1:0] sub;
  logic        slot_free;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign c         = in_data_i.in_byte;
  assign eos       = in_data_i.end_of_stream;
  assign name_byte = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h30 && c <= 8'h39) || (c == hefilt_pkg::ChHash);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    hefilt_pkg::ent_t e;
    logic [2:0] ci;
    seq_sel  = 24'h0;
    slen_sel = 2'd0;
    for (int k = 0; k < NE; k++) begin
      e = hefilt_pkg::entry(6'(k));
      hit[k] = match_q[k] && (len_q == LenW'(e.nlen));
      ci = e.nlen - 3'd1 - len_q[2:0];
      match_d[k] = match_q[k] && (len_q < LenW'(e.nlen)) &&
                   (e.nm[{ci, 3'b000} +: 8] == c);
      if (k >= KE && hit[k]) begin
        seq_sel  = seq_sel | e.seq;
        slen_sel = slen_sel | e.slen;
      end
    end
  end

  assign keep  = ((len_q != '0) && (store_q[0] == hefilt_pkg::ChHash)) || (|hit[KE-1:0]);
  assign found = |hit[NE-1:KE];

  always_comb begin
    state_d   = state_q;
    inside_d  = inside_q;
    len_d     = len_q;
    wr_en     = 1'b0;
    pre_d     = pre_q;
    pre_len_d = pre_len_q;
    emit_n_d  = emit_n_q;
    suf_v_d   = suf_v_q;
    suf_d     = suf_q;
    idx_d     = idx_q;
    total_d   = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d     = out_q;
    if (accept) begin
      pre_len_d = 3'd0;
      emit_n_d  = '0;
      suf_v_d   = 1'b0;
      suf_d     = c;
      idx_d     = '0;
      priority if (eos) begin
        if (inside_q) begin
          pre_d = hefilt_pkg::AmpLit; pre_len_d = 3'd5; emit_n_d = len_q;
          inside_d = 1'b0; len_d = '0;
        end
      end else if (!inside_q) begin
        if (c == hefilt_pkg::ChAmp) begin
          inside_d = 1'b1; len_d = '0;
        end else begin
          suf_v_d = 1'b1;
        end
      end else if (c == hefilt_pkg::ChSemi) begin
        inside_d = 1'b0; len_d = '0;
        if (keep) begin
          pre_d = 40'(hefilt_pkg::ChAmp); pre_len_d = 3'd1; emit_n_d = len_q;
          suf_v_d = 1'b1; suf_d = hefilt_pkg::ChSemi;
        end else if (found) begin
          pre_d = 40'(seq_sel); pre_len_d = {1'b0, slen_sel};
        end else begin
          pre_d = 40'(hefilt_pkg::FffdSeq); pre_len_d = 3'd3;
        end
      end else if (!name_byte || len_q >= LenW'(MaxLen)) begin
        pre_d = hefilt_pkg::AmpLit; pre_len_d = 3'd5; emit_n_d = len_q;
        len_d = '0;
        if (c == hefilt_pkg::ChAmp) begin
          inside_d = 1'b1;
        end else begin
          inside_d = 1'b0; suf_v_d = 1'b1;
        end
      end else begin
        wr_en = 1'b1;
        len_d = len_q + LenW'(1);
      end
      total_d = IdxW'(pre_len_d) + IdxW'(emit_n_d) + IdxW'(suf_v_d);
      if (total_d != '0) begin
        state_d = StEmit;
      end
    end else if (state_q == StEmit && slot_free) begin
      out_valid_d = 1'b1;
      out_d.out_byte   = emit_byte;
      out_d.end_of_run = (idx_q == total_q - IdxW'(1));
      idx_d = idx_q + IdxW'(1);
      if (idx_q == total_q - IdxW'(1)) begin
        state_d = StIdle;
      end
    end
  end

  always_comb begin
    pidx = pre_len_q - 3'd1 - idx_q[2:0];
    sub  = idx_q - IdxW'(pre_len_q);
    if (idx_q < IdxW'(pre_len_q)) begin
      emit_byte = pre_q[{pidx, 3'b000} +: 8];
    end else if (sub < IdxW'(emit_n_q)) begin
      emit_byte = store_q[sub[AddrW-1:0]];
    end else begin
      emit_byte = suf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      inside_q    <= 1'b0;
      len_q       <= '0;
      match_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      idx_q       <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      inside_q    <= inside_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      if (accept) begin
        match_q <= wr_en ? match_d : '1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q     <= pre_d;
    pre_len_q <= pre_len_d;
    emit_n_q  <= emit_n_d;
    suf_v_q   <= suf_v_d;
    suf_q     <= suf_d;
    if (wr_en) begin
      store_q[len_q[AddrW-1:0]] <= c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HEF_ASSERT(a_idx_in_range, clk_i, rst_ni, (state_q == StEmit) |-> (idx_q < total_q))
  `HEF_ASSERT_MSG(a_len_bound, clk_i, rst_ni, len_q <= LenW'(MaxLen), "name too long")
  `HEF_ASSERT(a_name_grows, clk_i, rst_ni, wr_en |=> (len_q == $past(len_q) + LenW'(1)))

endmodule
